@@ rtl/core/sha256_pkg.sv @@
// Shared types, constants and round functions of the SHA-256 hash core.
// Depends on nothing; every module of the core refers to it by scoped names.
package sha256_pkg;

  // One 32-bit word and the eight-word hash state, word 0 in the lowest bits.
  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  // Sequencer states of the core.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE
  } state_e;

  // Control of the block buffer and message schedule window.
  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       word_en;
  } sched_ctrl_t;

  // Control of the round unit.
  typedef struct packed {
    logic       load;
    logic       step;
    logic [5:0] idx;
  } round_ctrl_t;

  localparam int unsigned RoundCount = 64;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [5:0] LengthOffset = 6'd56;
  localparam logic [5:0] LastByte = 6'd63;
  localparam logic [5:0] LastRound = 6'(RoundCount - 1);

  // Initial hash value, H0 in the lowest word.
  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  // Round constants.
  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;
      6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;
      6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;
      6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;
      6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;
      6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;
      6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;
      6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;
      6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;
      6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;
      6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;
      6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;
      6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;
      6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;
      6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;
      6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;
      6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;
      6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;
      6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;
      6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;
      6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;
      6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;
      6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;
      6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;
      6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;
      6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;
      6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;
      6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;
      6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;
      6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;
      6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;
      6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;
      6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

@@ rtl/core/sha256_message_hash.sv @@
// Top level of the SHA-256 hash core: sequencer, chain value, counters, output.
// Depends on sha256_pkg, sha256_sched and sha256_round.
//
// Usage: the slave channel takes one item per message byte. tdata carries the
// byte, tuser says whether the byte is present, tlast marks the end of the
// message (an item with tlast and no byte ends the message without data).
// The master channel gives one item per message: the 256-bit digest.
// Timing: a byte that does not complete a 64-byte block is taken without a
// stall. The byte that completes a block starts a compression on the one
// shared round unit: the rounds and then the add into the chain value, during
// which tready is low. At end of message the padding bytes are pushed one per
// cycle through the same path (9 to 72 bytes) with one or two compressions.
// The digest sits in its own output register, so the next message is taken
// while it waits. If the receiver stalls and a second digest is ready, the
// core holds in its update state until the first one is taken.
// Reset restores the initial hash value and clears counters and output valid.
module sha256_message_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] msg_byte
  input  logic         s_axis_tuser_i,   // [0] byte_present
  input  logic         s_axis_tlast_i,   // end_of_message
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o    // digest_word_0 [31:0] .. digest_word_7 [255:224]
);

  sha256_pkg::state_e state_q, state_d;
  logic [5:0]  round_q, round_d;
  logic [5:0]  bytes_q, bytes_d;
  logic [63:0] bits_q, bits_d;
  logic        pad_q, pad_d;
  logic        marker_q, marker_d;
  logic        len_q, len_d;
  logic        out_valid_q, out_valid_d;
  sha256_pkg::hash_t chain_q, chain_d;
  sha256_pkg::hash_t digest_q, digest_d;
  sha256_pkg::hash_t vars, chain_sum;
  sha256_pkg::word_t sched_word;
  sha256_pkg::sched_ctrl_t sched_ctrl;
  sha256_pkg::round_ctrl_t round_ctrl;
  logic       accept, push, block_full, finish;
  logic [7:0] push_byte, pad_byte, len_byte;

  assign s_axis_tready_o = (state_q == sha256_pkg::ST_IDLE);
  assign accept = s_axis_tvalid_i & s_axis_tready_o;

  // Padding bytes: marker, zeros, then the bit count most significant byte first.
  assign len_byte = 8'(bits_q >> {~bytes_q[2:0], 3'b000});
  always_comb begin
    if (!marker_q) begin
      pad_byte = sha256_pkg::PadMarker;
    end else if (len_q || bytes_q == sha256_pkg::LengthOffset) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign push = (accept & s_axis_tuser_i) | (state_q == sha256_pkg::ST_PAD);
  assign push_byte = (state_q == sha256_pkg::ST_PAD) ? pad_byte : s_axis_tdata_i;
  assign block_full = push && (bytes_q == sha256_pkg::LastByte);
  assign finish = pad_q & len_q;

  // Chain value plus the working variables, word by word.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_sum[i] = chain_q[i] + vars[i];
    end
  end

  // Sequencer: next state and datapath control.
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    bytes_d     = push ? bytes_q + 6'd1 : bytes_q;
    bits_d      = (accept && s_axis_tuser_i) ? bits_q + 64'd8 : bits_q;
    pad_d       = pad_q;
    marker_d    = marker_q;
    len_d       = len_q;
    chain_d     = chain_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;

    sched_ctrl.byte_en  = push;
    sched_ctrl.byte_val = push_byte;
    sched_ctrl.word_en  = (state_q == sha256_pkg::ST_ROUND);
    round_ctrl.load     = block_full;
    round_ctrl.step     = (state_q == sha256_pkg::ST_ROUND);
    round_ctrl.idx      = round_q;

    case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (accept) begin
          pad_d = s_axis_tlast_i;
          if (block_full) begin
            state_d = sha256_pkg::ST_ROUND;
            round_d = 6'd0;
          end else if (s_axis_tlast_i) begin
            state_d = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        marker_d = 1'b1;
        if (marker_q && bytes_q == sha256_pkg::LengthOffset) begin
          len_d = 1'b1;
        end
        if (block_full) begin
          state_d = sha256_pkg::ST_ROUND;
          round_d = 6'd0;
        end
      end
      sha256_pkg::ST_ROUND: begin
        round_d = round_q + 6'd1;
        if (round_q == sha256_pkg::LastRound) begin
          state_d = sha256_pkg::ST_UPDATE;
        end
      end
      sha256_pkg::ST_UPDATE: begin
        if (!finish) begin
          chain_d = chain_sum;
          state_d = pad_q ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
        end else if (!out_valid_q || m_axis_tready_i) begin
          // Hand the digest to the output register and start a new message.
          digest_d    = chain_sum;
          out_valid_d = 1'b1;
          chain_d     = sha256_pkg::InitHash;
          bits_d      = 64'd0;
          pad_d       = 1'b0;
          marker_d    = 1'b0;
          len_d       = 1'b0;
          state_d     = sha256_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and chain registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha256_pkg::ST_IDLE;
      round_q     <= 6'd0;
      bytes_q     <= 6'd0;
      bits_q      <= 64'd0;
      pad_q       <= 1'b0;
      marker_q    <= 1'b0;
      len_q       <= 1'b0;
      out_valid_q <= 1'b0;
      chain_q     <= sha256_pkg::InitHash;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      bytes_q     <= bytes_d;
      bits_q      <= bits_d;
      pad_q       <= pad_d;
      marker_q    <= marker_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      chain_q     <= chain_d;
    end
  end

  // Digest output register.
  always_ff @(posedge clk_i) begin
    digest_q <= digest_d;
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .word_o (sched_word)
  );

  sha256_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (round_ctrl),
    .chain_i (chain_q),
    .word_i  (sched_word),
    .vars_o  (vars)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = digest_q;

endmodule

@@ rtl/core/sha256_sched.sv @@
// Block buffer and message schedule window of the SHA-256 core.
// Depends on sha256_pkg for the schedule functions and the control struct.
module sha256_sched (
  input  logic                    clk_i,
  input  sha256_pkg::sched_ctrl_t ctrl_i,
  output sha256_pkg::word_t       word_o
);

  // Sixteen words, word 0 in the top bits; bytes shift in at the bottom.
  logic [511:0] window_q, window_d;
  sha256_pkg::word_t w0, w1, w9, w14, w_new;

  assign w0  = window_q[511:480];
  assign w1  = window_q[479:448];
  assign w9  = window_q[223:192];
  assign w14 = window_q[63:32];

  // Next schedule word from the sliding window.
  assign w_new = w0 + sha256_pkg::small_sigma0(w1) + w9 + sha256_pkg::small_sigma1(w14);

  assign word_o = w0;

  // Byte fill during input, word shift during the rounds.
  always_comb begin
    window_d = window_q;
    if (ctrl_i.byte_en) begin
      window_d = {window_q[503:0], ctrl_i.byte_val};
    end else if (ctrl_i.word_en) begin
      window_d = {window_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
  end

endmodule

@@ rtl/core/sha256_round.sv @@
// Shared SHA-256 round unit: the working variables a..h and one round per step.
// Depends on sha256_pkg for the round functions, constants and control struct.
module sha256_round (
  input  logic                    clk_i,
  input  sha256_pkg::round_ctrl_t ctrl_i,
  input  sha256_pkg::hash_t       chain_i,
  input  sha256_pkg::word_t       word_i,
  output sha256_pkg::hash_t       vars_o
);

  sha256_pkg::hash_t vars_q, vars_d;
  sha256_pkg::word_t t1, t2, choose, major;

  // Round datapath on a = word 0 through h = word 7.
  assign choose = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign major  = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1 = vars_q[7] + sha256_pkg::big_sigma1(vars_q[4]) + choose
            + sha256_pkg::round_k(ctrl_i.idx) + word_i;
  assign t2 = sha256_pkg::big_sigma0(vars_q[0]) + major;

  always_comb begin
    vars_d = vars_q;
    if (ctrl_i.load) begin
      vars_d = chain_i;
    end else if (ctrl_i.step) begin
      vars_d[7] = vars_q[6];
      vars_d[6] = vars_q[5];
      vars_d[5] = vars_q[4];
      vars_d[4] = vars_q[3] + t1;
      vars_d[3] = vars_q[2];
      vars_d[2] = vars_q[1];
      vars_d[1] = vars_q[0];
      vars_d[0] = t1 + t2;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q <= vars_d;
  end

  assign vars_o = vars_q;

endmodule

@@ bench/tb_sha256_message_hash.sv @@
// Self-checking bench for the streaming SHA-256 core sha256_message_hash.
// Depends on sha256_pkg and the core RTL; a local SHA-256 predictor derives
// each expected digest from the accepted byte items.
module tb_sha256_message_hash;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned QuietTail = 150;
  localparam int unsigned DrainCycles = 300;

  // Round constants of SHA-256.
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Chain value at the start of every message, H0 first.
  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthSlot = 6'd56;

  // One slave-side item as the core sees it.
  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       eom;
  } hash_item_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i = '0;   // [7:0] msg_byte
  logic         s_axis_tuser_i = 1'b0; // [0] byte_present
  logic         s_axis_tlast_i = 1'b0; // end_of_message
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [255:0] m_axis_tdata_o;        // digest_word_0 [31:0] .. digest_word_7 [255:224]

  hash_item_t         pending_items[$];
  sha256_pkg::hash_t  digest_q[$];
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;
  logic               quiet = 1'b0;
  int unsigned        src_idle = 0;
  int unsigned        sink_idle = 0;

  // Predictor state: chain value, block buffer, fill level, bit count.
  logic [31:0] hash_state [8];
  logic [31:0] blk_words [16];
  logic [5:0]  blk_fill;
  logic [63:0] msg_bits;

  sha256_message_hash dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = StartHash[i];
    blk_fill = '0;
    msg_bits = '0;
  endfunction

  // One 64-round compression of the buffered block into the chain value.
  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, x, y;
    for (int t = 0; t < 16; t++) w[t] = blk_words[t];
    for (int t = 16; t < 64; t++) begin
      x = w[t-15];
      y = w[t-2];
      w[t] = w[t-16] + w[t-7] + (ror(x, 7) ^ ror(x, 18) ^ (x >> 3))
             + (ror(y, 17) ^ ror(y, 19) ^ (y >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endfunction

  // Bytes enter the block big-endian; a full block is compressed at once.
  function automatic void absorb_byte(input logic [7:0] b);
    blk_words[blk_fill[5:2]] = (blk_fill[1:0] == 2'd0) ? {24'h0, b}
                                : {blk_words[blk_fill[5:2]][23:0], b};
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) compress_block();
  endfunction

  // Apply one accepted item; an end mark pads the message and yields a digest.
  function automatic void predict_digest(input hash_item_t it);
    sha256_pkg::hash_t d;
    if (it.present) begin
      absorb_byte(it.data);
      msg_bits = msg_bits + 64'd8;
    end
    if (it.eom) begin
      absorb_byte(PadByte);
      while (blk_fill != LengthSlot) absorb_byte(8'h00);
      for (int k = 7; k >= 0; k--) absorb_byte(msg_bits[8*k +: 8]);
      for (int i = 0; i < 8; i++) d[i] = hash_state[i];
      digest_q = {digest_q, d};
      restart_message();
    end
  endfunction

  function automatic void report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endfunction

  // Slave-side driver: holds each item until accepted, idles in short bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= '0;
      s_axis_tuser_i <= 1'b0;
      s_axis_tlast_i <= 1'b0;
      src_idle <= 0;
      quiet <= 1'b0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i) predict_digest(pending_items.pop_front());
      quiet <= (pending_items.size() <= QuietTail);
      if (src_idle != 0) begin
        src_idle <= src_idle - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_items.size() == 0) begin
        s_axis_tvalid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        s_axis_tvalid_i <= 1'b0;
        src_idle <= $urandom_range(0, 3);
      end else begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= pending_items[0].data;
        s_axis_tuser_i <= pending_items[0].present;
        s_axis_tlast_i <= pending_items[0].eom;
      end
    end
  end

  // Master-side monitor: checks each digest against the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    sha256_pkg::hash_t got;
    sha256_pkg::hash_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      sink_idle <= 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("digest %h with no message pending", got));
        end else begin
          want = digest_q.pop_front();
          for (int i = 0; i < 8; i++) begin
            if (got[i] !== want[i])
              report_mismatch($sformatf("digest_word_%0d got %h expected %h",
                                        i, got[i], want[i]));
          end
        end
      end
      if (sink_idle != 0) begin
        sink_idle <= sink_idle - 1;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        sink_idle <= $urandom_range(0, 3);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  function automatic void add_item(input logic [7:0] data, input logic present,
                                   input logic eom);
    hash_item_t it;
    it.data = data;
    it.present = present;
    it.eom = eom;
    pending_items = {pending_items, it};
  endfunction

  // Timeout guard.
  initial begin
    while (cycle_count < CycleLimit) @(posedge clk_i);
    $display("tb_sha256_message_hash: errors");
    $finish;
  end

  // Stimulus, reset and end of run.
  initial begin
    int unsigned counted;
    int unsigned messages;
    int unsigned msg_len;
    int unsigned pick;
    bit          mark_on_byte;
    int unsigned edge_lens [11];

    edge_lens = '{54, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    restart_message();

    // Directed: empty message, single extreme bytes, "abc", ignored items,
    // and an empty final item after data.
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'h5a, 1'b0, 1'b0);
    add_item(8'hff, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'h61, 1'b1, 1'b0);
    add_item(8'h62, 1'b1, 1'b0);
    add_item(8'h63, 1'b1, 1'b1);
    add_item(8'ha5, 1'b1, 1'b0);
    add_item(8'hff, 1'b0, 1'b0);
    add_item(8'h3c, 1'b1, 1'b0);
    add_item(8'hc3, 1'b0, 1'b1);
    add_item(8'h00, 1'b0, 1'b1);

    // Random messages, weighted toward short ones and block boundaries.
    counted = 0;
    messages = 0;
    while (counted < 1000 || messages < 40) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) msg_len = $urandom_range(0, 20);
      else if (pick == 6) msg_len = edge_lens[$urandom_range(0, 10)];
      else if (pick == 7) msg_len = $urandom_range(20, 70);
      else if (pick == 8) msg_len = $urandom_range(0, 140);
      else msg_len = 0;
      mark_on_byte = (msg_len != 0) && $urandom_range(0, 1);
      for (int unsigned n = 0; n < msg_len; n++) begin
        if ($urandom_range(0, 11) == 0) add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_item(8'($urandom_range(0, 255)), 1'b1, mark_on_byte && (n == msg_len - 1));
        counted++;
      end
      if (!mark_on_byte) begin
        add_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        counted++;
      end
      messages++;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_sha256_message_hash: clean");
    end else begin
      $display("tb_sha256_message_hash: errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sha256_pkg.sv
rtl/core/sha256_sched.sv
rtl/core/sha256_round.sv
rtl/core/sha256_message_hash.sv
bench/tb_sha256_message_hash.sv
